### src/cbf_pkg.sv
// Shared constants and the Bernstein weight function of the cubic Bezier flattener.
package cbf_pkg;

  localparam int SegmentsDef = 50;
  localparam int CoordW      = 16;
  localparam int NumCoords   = 8;
  localparam int NumTerms    = 4;
  localparam int NumLanes    = 2;
  localparam int QuotBits    = 16;

  // Integer Bernstein weight of term k at step j of n (before division by n cubed).
  function automatic longint bez_weight(input int n, input int j, input int k);
    longint u;
    longint jj;
    u  = longint'(n - j);
    jj = longint'(j);
    case (k)
      0:       return u * u * u;
      1:       return 3 * u * u * jj;
      2:       return 3 * u * jj * jj;
      default: return jj * jj * jj;
    endcase
  endfunction

endpackage

### src/cubic_bezier_flattener.sv
// Cubic Bezier flattener: uniform steps in t, exact rounded Bernstein sums, deep pipeline.
//
// One input transaction carries a whole cubic segment: start point, two handles and
// end point, each as signed Q12.4 x and y. The block answers with SEGMENTS output
// transactions, the curve points at t = j/SEGMENTS for j = 1 .. SEGMENTS, in order;
// the last one carries out_last_point and equals the end point exactly.
// A segment is held in an input register while a step counter issues one point per
// cycle into the pipeline, so unless out_ready stalls it the block delivers one point
// per cycle; the next segment is accepted in the cycle that issues the last point of
// the current one, so there is no gap between segments.
// Each point passes six register stages: weight table lookup, multiply, two add
// stages, the two halves of a multiplication by the reciprocal of the constant
// divisor 2*SEGMENTS^3, and a final add that yields the rounded quotient.
// When out_ready is low with a point at the output, the whole pipeline and the step
// counter freeze together, nothing is lost or repeated, and in_ready stays low while
// a held segment is not issuing its last point. A synchronous reset clears all valid
// bits and the counter; the block accepts a segment in the first cycle after reset.
module cubic_bezier_flattener
  import cbf_pkg::*;
#(
  parameter int SEGMENTS = SegmentsDef
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CoordW-1:0] in_start_x,
  input  logic signed [CoordW-1:0] in_start_y,
  input  logic signed [CoordW-1:0] in_ctrl_a_x,
  input  logic signed [CoordW-1:0] in_ctrl_a_y,
  input  logic signed [CoordW-1:0] in_ctrl_b_x,
  input  logic signed [CoordW-1:0] in_ctrl_b_y,
  input  logic signed [CoordW-1:0] in_end_x,
  input  logic signed [CoordW-1:0] in_end_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CoordW-1:0] out_point_x,
  output logic signed [CoordW-1:0] out_point_y,
  output logic                     out_last_point
);

  localparam longint Den   = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;
  localparam int     DenW  = $clog2(Den + 1);
  localparam int     JW    = $clog2(SEGMENTS + 1);
  localparam int     ProdW = DenW + CoordW + 1;
  localparam int     SumW  = ProdW + 1;
  localparam int     AccW  = DenW + CoordW + 3;
  // Rounding half plus the offset that makes every quotient non-negative.
  localparam longint Offset = Den + Den * (longint'(1) << QuotBits);
  localparam logic [JW-1:0] LastJ = JW'(SEGMENTS);

  // The dividend stays below 2**XW, and for every such value floor(x / Dvs)
  // equals (x * Recip) >> ShR.
  localparam longint Dvs   = 2 * Den;
  localparam int     DivW  = $clog2(Dvs);
  localparam int     XW    = QuotBits + DivW;
  localparam int     ShR   = XW + DivW;
  localparam int     MW    = XW + 1;
  localparam int     LoW   = XW / 2;
  localparam int     HiW   = XW - LoW;
  localparam int     PW    = XW + MW;
  localparam longint Recip = ((longint'(1) << ShR) + Dvs - 1) / Dvs;
  localparam logic [MW-1:0] RecipM = MW'(Recip);

  // Constant weight table, one row per term.
  logic [DenW-1:0] w_tab [NumTerms][SEGMENTS+1];
  for (genvar k = 0; k < NumTerms; k++) begin : g_wk
    for (genvar g = 0; g <= SEGMENTS; g++) begin : g_wj
      assign w_tab[k][g] = DenW'(bez_weight(SEGMENTS, g, k));
    end
  end

  logic adv;
  logic accept;
  logic issue;

  // Held segment and step counter.
  logic                     hold_v_r, hold_v_nxt;
  logic [JW-1:0]            j_r, j_nxt;
  logic signed [CoordW-1:0] hold_c_r [NumCoords];

  // Pipeline stages.
  logic                     s1_v_r, s1_last_r;
  logic [DenW-1:0]          s1_w_r [NumTerms];
  logic signed [CoordW-1:0] s1_c_r [NumLanes][NumTerms];
  logic                     s2_v_r, s2_last_r;
  logic signed [ProdW-1:0]  s2_m_r [NumLanes][NumTerms];
  logic                     s3_v_r, s3_last_r;
  logic signed [SumW-1:0]   s3_lo_r [NumLanes];
  logic signed [SumW-1:0]   s3_hi_r [NumLanes];
  logic signed [AccW-1:0]   acc_nxt [NumLanes];
  logic                     s4_v_r, s4_last_r;
  logic [XW-1:0]            s4_d_r [NumLanes];
  logic                     s5_v_r, s5_last_r;
  logic [LoW+MW-1:0]        s5_pl_r [NumLanes];
  logic [HiW+MW-1:0]        s5_ph_r [NumLanes];
  logic [PW-1:0]            qsum_nxt [NumLanes];
  logic                     s6_v_r, s6_last_r;
  logic [QuotBits-1:0]      s6_q_r [NumLanes];

  assign adv      = out_ready || !s6_v_r;
  assign issue    = hold_v_r && adv;
  assign in_ready = !hold_v_r || (adv && (j_r == LastJ));
  assign accept   = in_valid && in_ready;

  always_comb begin
    hold_v_nxt = hold_v_r;
    j_nxt      = j_r;
    if (issue) begin
      if (j_r == LastJ) begin
        hold_v_nxt = 1'b0;
        j_nxt      = JW'(1);
      end else begin
        j_nxt = j_r + JW'(1);
      end
    end
    if (accept) begin
      hold_v_nxt = 1'b1;
      j_nxt      = JW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      j_r      <= '0;
    end else begin
      hold_v_r <= hold_v_nxt;
      j_r      <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_c_r[0] <= in_start_x;
      hold_c_r[1] <= in_start_y;
      hold_c_r[2] <= in_ctrl_a_x;
      hold_c_r[3] <= in_ctrl_a_y;
      hold_c_r[4] <= in_ctrl_b_x;
      hold_c_r[5] <= in_ctrl_b_y;
      hold_c_r[6] <= in_end_x;
      hold_c_r[7] <= in_end_y;
    end
  end

  // Valid and last flags travel with the data and freeze together on a stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= hold_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
  end

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      acc_nxt[l]  = ((AccW'(s3_lo_r[l]) + AccW'(s3_hi_r[l])) <<< 1) + AccW'(Offset);
      qsum_nxt[l] = (PW'(s5_ph_r[l]) << LoW) + PW'(s5_pl_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r <= (j_r == LastJ);
      s2_last_r <= s1_last_r;
      s3_last_r <= s2_last_r;
      s4_last_r <= s3_last_r;
      s5_last_r <= s4_last_r;
      s6_last_r <= s5_last_r;
      for (int k = 0; k < NumTerms; k++) begin
        s1_w_r[k] <= w_tab[k][j_r];
        for (int l = 0; l < NumLanes; l++) begin
          s1_c_r[l][k] <= hold_c_r[2*k+l];
          s2_m_r[l][k] <= $signed({1'b0, s1_w_r[k]}) * s1_c_r[l][k];
        end
      end
      for (int l = 0; l < NumLanes; l++) begin
        s3_lo_r[l] <= SumW'(s2_m_r[l][0]) + SumW'(s2_m_r[l][1]);
        s3_hi_r[l] <= SumW'(s2_m_r[l][2]) + SumW'(s2_m_r[l][3]);
        // The offset sum is never negative, so its low bits are the dividend.
        s4_d_r[l]  <= acc_nxt[l][XW-1:0];
        s5_pl_r[l] <= s4_d_r[l][LoW-1:0] * RecipM;
        s5_ph_r[l] <= s4_d_r[l][XW-1:LoW] * RecipM;
        s6_q_r[l]  <= qsum_nxt[l][ShR +: QuotBits];
      end
    end
  end

  // Removing the offset flips the top bit of the quotient.
  assign out_valid      = s6_v_r;
  assign out_last_point = s6_last_r;
  assign out_point_x    = $signed(s6_q_r[0] ^ {1'b1, {(QuotBits-1){1'b0}}});
  assign out_point_y    = $signed(s6_q_r[1] ^ {1'b1, {(QuotBits-1){1'b0}}});

`ifndef SYNTH
  a_accept_on_last : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!hold_v_r || (issue && (j_r == LastJ))))
    else $error("segment accepted while the held segment still has points to issue");

  a_step_range : assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> ((j_r != '0) && (j_r <= LastJ)))
    else $error("step counter outside one to SEGMENTS while a segment is held");

  a_hold_kept : assert property (@(posedge clk) disable iff (!rst_n)
    (hold_v_r && (!issue || (j_r != LastJ))) |=> hold_v_r)
    else $error("held segment dropped before its last point was issued");
`endif

endmodule

### dv/tb_cubic_bezier_flattener.sv
// Self-checking testbench for the cubic Bezier flattener: directed table, random segments, stalls.
`timescale 1ns / 1ps

module tb_cubic_bezier_flattener;
  import cbf_pkg::*;

  localparam int NSEG       = SegmentsDef;
  localparam int NUM_RANDOM = 360;
  localparam int PRINT_CAP  = 40;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t ex;
    coord_t ey;
  } segment_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } curve_point_t;

  typedef struct {
    segment_t seg;
    bit       fixed;
    coord_t   fx;
    coord_t   fy;
  } stim_row_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_ctrl_a_x = '0;
  coord_t in_ctrl_a_y = '0;
  coord_t in_ctrl_b_x = '0;
  coord_t in_ctrl_b_y = '0;
  coord_t in_end_x = '0;
  coord_t in_end_y = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t out_point_x;
  coord_t out_point_y;
  logic   out_last_point;

  curve_point_t expected_points[$];
  stim_row_t    stim_table[$];
  int           mismatch_count = 0;
  int           points_checked = 0;
  int           segments_sent = 0;
  int           long_stalls = 0;
  int           stall_left = 0;
  bit           steady = 1'b0;

  always #1 clk = ~clk;

  cubic_bezier_flattener u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_ctrl_a_x    (in_ctrl_a_x),
    .in_ctrl_a_y    (in_ctrl_a_y),
    .in_ctrl_b_x    (in_ctrl_b_x),
    .in_ctrl_b_y    (in_ctrl_b_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point)
  );

  // One axis of the curve at step j: exact weighted sum, then divide by N cubed,
  // rounding to nearest with halves going up (also for negative values).
  function automatic coord_t bezier_axis(coord_t p0, coord_t h0, coord_t h1, coord_t p1,
                                         int step);
    longint rs;
    longint js;
    longint num;
    longint den;
    longint q;
    rs  = longint'(NSEG - step);
    js  = longint'(step);
    den = 2 * longint'(NSEG) * NSEG * NSEG;
    num = rs * rs * rs * longint'(p0) + 3 * rs * rs * js * longint'(h0)
        + 3 * rs * js * js * longint'(h1) + js * js * js * longint'(p1);
    num = 2 * num + den / 2;
    q   = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return coord_t'(q);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d (point %0d)",
               $realtime, what, got, want, points_checked);
  endtask

  task automatic add_row(segment_t seg, bit fixed, coord_t fx, coord_t fy);
    stim_row_t row;
    row.seg   = seg;
    row.fixed = fixed;
    row.fx    = fx;
    row.fy    = fy;
    stim_table = {stim_table, row};
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Drives one segment and waits for its transaction; valid stays high into the
  // next segment when there is no gap.
  task automatic send_segment(segment_t seg, bit fixed, coord_t fx, coord_t fy);
    int gap;
    curve_point_t pt;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_start_x  <= seg.sx;
    in_start_y  <= seg.sy;
    in_ctrl_a_x <= seg.ax;
    in_ctrl_a_y <= seg.ay;
    in_ctrl_b_x <= seg.bx;
    in_ctrl_b_y <= seg.by;
    in_end_x    <= seg.ex;
    in_end_y    <= seg.ey;
    do @(posedge clk); while (!in_ready);
    for (int j = 1; j <= NSEG; j++) begin
      if (fixed) begin
        pt.x = fx;
        pt.y = fy;
      end else begin
        pt.x = bezier_axis(seg.sx, seg.ax, seg.bx, seg.ex, j);
        pt.y = bezier_axis(seg.sy, seg.ay, seg.by, seg.ey, j);
      end
      pt.last = (j == NSEG);
      expected_points = {expected_points, pt};
    end
    segments_sent++;
  endtask

  task automatic drain_points();
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0:       return coord_t'($urandom_range(0, 65535));
      1:       return coord_t'(int'($urandom_range(0, 1023)) - 512);
      default: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // Result side: checks every output transaction and throttles out_ready.
  always @(posedge clk) begin
    curve_point_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected point x", out_point_x, 0);
      end else begin
        want = expected_points.pop_front();
        if (out_point_x !== want.x) report_mismatch("point_x", out_point_x, want.x);
        if (out_point_y !== want.y) report_mismatch("point_y", out_point_y, want.y);
        if (out_last_point !== want.last)
          report_mismatch("last_point", out_last_point, want.last);
      end
      points_checked++;
    end
    if (steady) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 99) < 20) begin
      out_ready <= 1'b0;
      if ($urandom_range(0, 99) < 4) begin
        stall_left <= $urandom_range(15, 60);
        long_stalls++;
      end else begin
        stall_left <= $urandom_range(0, 2);
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    #10_000_000;
    $display("Timeout: %0d points still expected", expected_points.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    segment_t seg;
    int       mode;
    int       n_directed;

    // Constant curves: every sample equals the common point.
    add_row('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
            1'b1, 16'sd0, 16'sd0);
    add_row('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh7fff, 16'sh8000}, 1'b1, 16'sh7fff, 16'sh8000);
    add_row('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
              16'sh8000, 16'sh7fff}, 1'b1, 16'sh8000, 16'sh7fff);
    add_row('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
              16'sh5555, 16'shaaaa}, 1'b1, 16'sh5555, 16'shaaaa);
    // Full-range swings, where the samples run closest to the 16-bit limits.
    add_row('{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh8000, 16'sh7fff}, 1'b0, '0, '0);
    add_row('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
              16'sh7fff, 16'sh8000}, 1'b0, '0, '0);
    add_row('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
              16'sh7fff, 16'sh7fff}, 1'b0, '0, '0);
    // Only the end point set: at the midpoint the sample of the first two rows is an
    // exact half, and negative halves must round upwards.
    add_row('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd20, 16'sd20},
            1'b0, '0, '0);
    add_row('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd4, 16'sd4},
            1'b0, '0, '0);
    add_row('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 16'sh8000},
            1'b0, '0, '0);
    // A general curve, crossed handles, a closed loop and a straight line.
    add_row('{-16'sd100, 16'sd50, 16'sd0, 16'sd25, 16'sd200, -16'sd50, 16'sd300,
              -16'sd75}, 1'b0, '0, '0);
    add_row('{16'sd0, 16'sd0, 16'sd800, 16'sd800, -16'sd800, 16'sd800, 16'sd16,
              16'sd0}, 1'b0, '0, '0);
    add_row('{16'sd0, 16'sd0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sd0,
              16'sd0}, 1'b0, '0, '0);
    add_row('{16'sd1, -16'sd1, 16'sd2, -16'sd2, -16'sd3, 16'sd3, 16'sh4000,
              -16'sh4000}, 1'b0, '0, '0);
    n_directed = stim_table.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i])
      send_segment(stim_table[i].seg, stim_table[i].fixed, stim_table[i].fx,
                   stim_table[i].fy);

    // Let the pipeline run dry once before the random part starts.
    in_valid <= 1'b0;
    drain_points();

    for (int k = 0; k < NUM_RANDOM; k++) begin
      steady = (k >= 150 && k < 190);
      if (k == 250) begin
        in_valid <= 1'b0;
        drain_points();
      end
      mode = $urandom_range(0, 99);
      mode = (mode < 65) ? 0 : (mode < 92) ? 1 : 2;
      seg.sx = rand_coord(mode);
      seg.sy = rand_coord(mode);
      seg.ax = rand_coord(mode);
      seg.ay = rand_coord(mode);
      seg.bx = rand_coord(mode);
      seg.by = rand_coord(mode);
      seg.ex = rand_coord(mode);
      seg.ey = rand_coord(mode);
      send_segment(seg, 1'b0, '0, '0);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    drain_points();
    repeat (60) @(posedge clk);

    $display("Run covered %0d segments (%0d from the directed table), %0d points checked.",
             segments_sent, n_directed, points_checked);
    $display("Result side saw %0d long stalls; %0d mismatches in total.",
             long_stalls, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/cbf_pkg.sv
src/cubic_bezier_flattener.sv
dv/tb_cubic_bezier_flattener.sv
